// ===== hdl/tlt_pkg.sv =====
`timescale 1ns / 1ps

package tlt_pkg;

  // field widths of the command and result beats
  localparam int CMD_W = 3;
  localparam int IDX_W = 6;
  localparam int DL_W  = 32;

  // deadline of the sentinel entry
  localparam logic [DL_W-1:0] DL_ALL_ONES = 32'hffff_ffff;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

  // entry status
  typedef enum logic [1:0] {
    STAT_FREE  = 2'd0,
    STAT_ALLOC = 2'd1,
    STAT_INUSE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_RST_SCAN,
    ST_SET_CHK,
    ST_SET_WALK,
    ST_SET_LINK,
    ST_FREE_CHK,
    ST_FREE_WALK,
    ST_FREE_DONE,
    ST_HEAD_RD,
    ST_HEAD_WAIT
  } state_t;

endpackage

// ===== hdl/timeout_list_timer_pool.sv =====
`timescale 1ns / 1ps
// Sequence: alloc scans the status memory from entry 0 for the lowest free entry, reset_count
// scans entries 1 to TIMER_COUNT-1, set walks the list from the head and free may walk it too,
// one entry or list element per step, through the single read port of the entry memories; every
// command then reads the head deadline, and the result beat waits for out_ready.
// Throughput: one command at a time, a new beat is taken once the previous one is finished.
// Reset: after rst_n the status memory is swept, entry by entry, before the first beat.
module timeout_list_timer_pool #(
  parameter int TIMER_COUNT = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tlt_pkg::CMD_W-1:0]  in_command,
  input  logic [tlt_pkg::IDX_W-1:0]  in_timer_index,
  input  logic [tlt_pkg::DL_W-1:0]   in_timeout,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [tlt_pkg::IDX_W-1:0]  out_granted_index,
  output logic [tlt_pkg::IDX_W-1:0]  out_head_index,
  output logic [tlt_pkg::DL_W-1:0]   out_earliest_deadline
);
  import tlt_pkg::*;

  localparam int IW = $clog2(TIMER_COUNT);
  localparam logic [IW-1:0] LAST = IW'(TIMER_COUNT - 1);

  // entry memories
  status_t           status_mem   [TIMER_COUNT];
  logic [DL_W-1:0]   deadline_mem [TIMER_COUNT];
  logic [IW-1:0]     link_mem     [TIMER_COUNT];

  // memory ports
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_addr_q;
  status_t           status_q;
  logic [DL_W-1:0]   deadline_raw;
  logic [IW-1:0]     link_raw;
  logic [DL_W-1:0]   dl_q;
  logic [IW-1:0]     link_q;
  logic              st_we;
  logic [IW-1:0]     st_wa;
  status_t           st_wd;
  logic              dl_we;
  logic [IW-1:0]     dl_wa;
  logic [DL_W-1:0]   dl_wd;
  logic              ln_we;
  logic [IW-1:0]     ln_wa;
  logic [IW-1:0]     ln_wd;

  // control and working registers
  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [DL_W-1:0]   work_r, work_nxt;
  logic [DL_W-1:0]   count_r, count_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     prev_r, prev_nxt;
  logic              has_prev_r, has_prev_nxt;
  logic [IW-1:0]     nlink_r, nlink_nxt;
  logic              ok_r, ok_nxt;
  logic [IW-1:0]     grant_r, grant_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [IDX_W-1:0]  out_grant_r, out_grant_nxt;
  logic [IDX_W-1:0]  out_head_r, out_head_nxt;
  logic [DL_W-1:0]   out_dl_r, out_dl_nxt;
  logic              in_acc;
  logic              idx_valid;

  // status memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[st_wa] <= st_wd;
    end
    status_q <= status_mem[rd_addr];
  end

  // deadline memory
  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_mem[dl_wa] <= dl_wd;
    end
    deadline_raw <= deadline_mem[rd_addr];
  end

  // link memory
  always_ff @(posedge clk) begin
    if (ln_we) begin
      link_mem[ln_wa] <= ln_wd;
    end
    link_raw <= link_mem[rd_addr];
  end

  // sentinel reads as all-ones deadline and link to itself
  assign dl_q   = (rd_addr_q == '0) ? DL_ALL_ONES : deadline_raw;
  assign link_q = (rd_addr_q == '0) ? '0 : link_raw;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign idx_valid = (in_timer_index != '0) && (32'(in_timer_index) < TIMER_COUNT);

  assign out_valid             = out_valid_r;
  assign out_ok                = out_ok_r;
  assign out_granted_index     = out_grant_r;
  assign out_head_index        = out_head_r;
  assign out_earliest_deadline = out_dl_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    rd_addr_q   <= rd_addr;
    idx_r       <= idx_nxt;
    work_r      <= work_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    has_prev_r  <= has_prev_nxt;
    nlink_r     <= nlink_nxt;
    ok_r        <= ok_nxt;
    grant_r     <= grant_nxt;
    out_ok_r    <= out_ok_nxt;
    out_grant_r <= out_grant_nxt;
    out_head_r  <= out_head_nxt;
    out_dl_r    <= out_dl_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    idx_nxt       = idx_r;
    work_nxt      = work_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    has_prev_nxt  = has_prev_r;
    nlink_nxt     = nlink_r;
    ok_nxt        = ok_r;
    grant_nxt     = grant_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_grant_nxt = out_grant_r;
    out_head_nxt  = out_head_r;
    out_dl_nxt    = out_dl_r;
    rd_addr       = rd_addr_q;
    st_we         = 1'b0;
    st_wa         = idx_r;
    st_wd         = STAT_FREE;
    dl_we         = 1'b0;
    dl_wa         = idx_r;
    dl_wd         = work_r;
    ln_we         = 1'b0;
    ln_wa         = idx_r;
    ln_wd         = cur_r;

    // result beat leaves
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // sweep status after reset, sentinel in use
      ST_CLEAR: begin
        rd_addr = '0;
        st_we   = 1'b1;
        st_wa   = clr_r;
        st_wd   = (clr_r == '0) ? STAT_INUSE : STAT_FREE;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      // take a command beat
      ST_IDLE: begin
        if (in_acc) begin
          ok_nxt    = 1'b0;
          grant_nxt = '0;
          idx_nxt   = IW'(in_timer_index);
          case (in_command)
            CMD_ALLOC: begin
              rd_addr   = '0;
              state_nxt = ST_ALLOC_SCAN;
            end
            CMD_SET: begin
              if (idx_valid) begin
                rd_addr   = IW'(in_timer_index);
                work_nxt  = in_timeout + count_r;
                state_nxt = ST_SET_CHK;
              end else begin
                state_nxt = ST_HEAD_RD;
              end
            end
            CMD_FREE: begin
              if (idx_valid) begin
                rd_addr   = IW'(in_timer_index);
                state_nxt = ST_FREE_CHK;
              end else begin
                state_nxt = ST_HEAD_RD;
              end
            end
            CMD_RESET: begin
              work_nxt  = count_r;
              count_nxt = '0;
              rd_addr   = IW'(1);
              state_nxt = ST_RST_SCAN;
            end
            CMD_TICK: begin
              count_nxt = count_r + 1'b1;
              ok_nxt    = 1'b1;
              state_nxt = ST_HEAD_RD;
            end
            default: begin
              state_nxt = ST_HEAD_RD;
            end
          endcase
        end
      end

      // lowest free entry, one entry a cycle
      ST_ALLOC_SCAN: begin
        if (status_q == STAT_FREE) begin
          st_we     = 1'b1;
          st_wa     = rd_addr_q;
          st_wd     = STAT_ALLOC;
          ok_nxt    = 1'b1;
          grant_nxt = rd_addr_q;
          state_nxt = ST_HEAD_RD;
        end else if (rd_addr_q == LAST) begin
          state_nxt = ST_HEAD_RD;
        end else begin
          rd_addr = rd_addr_q + 1'b1;
        end
      end

      // rebase deadlines of in-use entries
      ST_RST_SCAN: begin
        if (status_q == STAT_INUSE) begin
          dl_we = 1'b1;
          dl_wa = rd_addr_q;
          dl_wd = deadline_raw - work_r;
        end
        if (rd_addr_q == LAST) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_HEAD_RD;
        end else begin
          rd_addr = rd_addr_q + 1'b1;
        end
      end

      // refuse set on an in-use entry, else store deadline and start walk
      ST_SET_CHK: begin
        if (status_q == STAT_INUSE) begin
          state_nxt = ST_HEAD_RD;
        end else begin
          st_we        = 1'b1;
          st_wd        = STAT_INUSE;
          dl_we        = 1'b1;
          ok_nxt       = 1'b1;
          cur_nxt      = head_r;
          has_prev_nxt = 1'b0;
          rd_addr      = head_r;
          state_nxt    = ST_SET_WALK;
        end
      end

      // walk to the first entry with an equal or later deadline
      ST_SET_WALK: begin
        if (work_r <= dl_q) begin
          ln_we = 1'b1;
          ln_wd = cur_r;
          if (has_prev_r) begin
            state_nxt = ST_SET_LINK;
          end else begin
            head_nxt  = idx_r;
            state_nxt = ST_HEAD_RD;
          end
        end else begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = link_q;
          rd_addr      = link_q;
        end
      end

      // point the predecessor at the new entry
      ST_SET_LINK: begin
        ln_we     = 1'b1;
        ln_wa     = prev_r;
        ln_wd     = idx_r;
        state_nxt = ST_HEAD_RD;
      end

      // unlink an in-use entry before freeing it
      ST_FREE_CHK: begin
        if (status_q == STAT_INUSE) begin
          if (head_r == idx_r) begin
            head_nxt  = link_q;
            state_nxt = ST_FREE_DONE;
          end else begin
            nlink_nxt = link_q;
            cur_nxt   = head_r;
            rd_addr   = head_r;
            state_nxt = ST_FREE_WALK;
          end
        end else begin
          state_nxt = ST_FREE_DONE;
        end
      end

      // find the predecessor of the freed entry
      ST_FREE_WALK: begin
        if (link_q == idx_r) begin
          ln_we     = 1'b1;
          ln_wa     = cur_r;
          ln_wd     = nlink_r;
          state_nxt = ST_FREE_DONE;
        end else if (cur_r == '0) begin
          state_nxt = ST_FREE_DONE;
        end else begin
          cur_nxt = link_q;
          rd_addr = link_q;
        end
      end

      ST_FREE_DONE: begin
        st_we     = 1'b1;
        st_wd     = STAT_FREE;
        ok_nxt    = 1'b1;
        state_nxt = ST_HEAD_RD;
      end

      // fetch the head deadline for the result
      ST_HEAD_RD: begin
        rd_addr   = head_r;
        state_nxt = ST_HEAD_WAIT;
      end

      // hand over the result once the output register is free
      ST_HEAD_WAIT: begin
        rd_addr = head_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_grant_nxt = IDX_W'(grant_r);
          out_head_nxt  = IDX_W'(head_r);
          out_dl_nxt    = dl_q;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tlt_pkg::*;

  localparam int TIMER_COUNT = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 650;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_TICK + 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted;
    logic [IDX_W-1:0] head;
    logic [DL_W-1:0]  deadline;
  } timer_reply_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] in_command = CMD_TICK;
  logic [IDX_W-1:0] in_timer_index = '0;
  logic [DL_W-1:0]  in_timeout = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_ok;
  logic [IDX_W-1:0] out_granted_index;
  logic [IDX_W-1:0] out_head_index;
  logic [DL_W-1:0]  out_earliest_deadline;

  // mirror of the timer pool
  status_t          pool_status [TIMER_COUNT];
  logic [DL_W-1:0]  pool_deadline [TIMER_COUNT];
  logic [IDX_W-1:0] pool_link [TIMER_COUNT];
  logic [IDX_W-1:0] list_first;
  logic [DL_W-1:0]  tick_now;

  timer_reply_t reply_q[$];
  int           fail_count = 0;
  int           stall_cycles = 0;
  logic         calm = 1'b0;

  timeout_list_timer_pool #(
    .TIMER_COUNT(TIMER_COUNT)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_timer_index       (in_timer_index),
    .in_timeout           (in_timeout),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ok               (out_ok),
    .out_granted_index    (out_granted_index),
    .out_head_index       (out_head_index),
    .out_earliest_deadline(out_earliest_deadline)
  );

  always #5 clk = ~clk;

  // pool state after reset
  function automatic void pool_clear();
    for (int i = 0; i < TIMER_COUNT; i++) begin
      pool_status[i]   = STAT_FREE;
      pool_deadline[i] = '0;
      pool_link[i]     = '0;
    end
    pool_status[0]   = STAT_INUSE;
    pool_deadline[0] = DL_ALL_ONES;
    list_first       = '0;
    tick_now         = '0;
  endfunction

  // apply one command to the mirror and return the reply it should produce
  function automatic timer_reply_t apply_timer_cmd(logic [CMD_W-1:0] cmd,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [DL_W-1:0] tmo);
    timer_reply_t     r;
    logic [DL_W-1:0]  d;
    logic [DL_W-1:0]  old;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] prev;
    r = '0;
    case (cmd)
      CMD_ALLOC: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (pool_status[i] == STAT_FREE) begin
            pool_status[i] = STAT_ALLOC;
            r.granted = IDX_W'(i);
            r.ok = 1'b1;
            break;
          end
        end
      end
      CMD_SET: begin
        if (idx != 0 && idx < TIMER_COUNT && pool_status[idx] != STAT_INUSE) begin
          d = tmo + tick_now;
          pool_deadline[idx] = d;
          pool_status[idx] = STAT_INUSE;
          cur = list_first;
          if (d <= pool_deadline[cur]) begin
            pool_link[idx] = cur;
            list_first = idx;
          end else begin
            prev = cur;
            // walk to the first entry due no earlier than the new one
            for (int n = 0; n < TIMER_COUNT; n++) begin
              prev = cur;
              cur = pool_link[cur];
              if (d <= pool_deadline[cur]) break;
            end
            pool_link[idx] = cur;
            pool_link[prev] = idx;
          end
          r.ok = 1'b1;
        end
      end
      CMD_FREE: begin
        if (idx != 0 && idx < TIMER_COUNT) begin
          if (pool_status[idx] == STAT_INUSE) begin
            if (list_first == idx) begin
              list_first = pool_link[idx];
            end else begin
              cur = list_first;
              for (int n = 0; n < TIMER_COUNT; n++) begin
                if (pool_link[cur] == idx) begin
                  pool_link[cur] = pool_link[idx];
                  break;
                end
                cur = pool_link[cur];
              end
            end
          end
          pool_status[idx] = STAT_FREE;
          r.ok = 1'b1;
        end
      end
      CMD_RESET: begin
        old = tick_now;
        tick_now = '0;
        for (int i = 1; i < TIMER_COUNT; i++)
          if (pool_status[i] == STAT_INUSE) pool_deadline[i] = pool_deadline[i] - old;
        r.ok = 1'b1;
      end
      CMD_TICK: begin
        tick_now = tick_now + 1;
        r.ok = 1'b1;
      end
      default: begin
      end
    endcase
    r.head = list_first;
    r.deadline = pool_deadline[list_first];
    return r;
  endfunction

  // random entry in the wanted state, any entry when there is none
  function automatic logic [IDX_W-1:0] pick_entry(status_t want);
    logic [IDX_W-1:0] hits[$];
    for (int i = 1; i < TIMER_COUNT; i++)
      if (pool_status[i] == want) hits.push_back(IDX_W'(i));
    if (hits.size() == 0) return IDX_W'($urandom_range(0, TIMER_COUNT - 1));
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic logic [DL_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(0, 40);
    if (r < 70) return $urandom;
    if (r < 85) return DL_ALL_ONES - $urandom_range(0, 40);
    return $urandom_range(0, 1000);
  endfunction

  function automatic void check_field(string fname, logic [DL_W-1:0] want,
                                      logic [DL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h actual %0h", fname, want, got);
      fail_count++;
    end
  endfunction

  // send one command beat and record its reply once accepted
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [DL_W-1:0] tmo);
    int gap;
    if (!calm && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_timer_index <= idx;
    in_timeout     <= tmo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reply_q.push_back(apply_timer_cmd(cmd, idx, tmo));
  endtask

  // hold the sender until every reply is back
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // reply check and receiver stalls
  always @(posedge clk) begin : reply_check
    timer_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $error("result beat with no command pending");
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        check_field("ok", DL_W'(want.ok), DL_W'(out_ok));
        check_field("granted_index", DL_W'(want.granted), DL_W'(out_granted_index));
        check_field("head_index", DL_W'(want.head), DL_W'(out_head_index));
        check_field("earliest_deadline", want.deadline, out_earliest_deadline);
      end
    end
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 8);
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // tick and ignored commands on an empty list
  task automatic test_idle_commands();
    send_cmd(CMD_TICK, 6'h3f, DL_ALL_ONES);
    send_cmd(CMD_UNUSED_LO, 6'd1, 32'h1);
    send_cmd(CMD_UNUSED_HI, 6'd2, 32'h2);
  endtask

  // alloc and set, including refusals and equal deadlines
  task automatic test_alloc_and_set();
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_SET, 6'd1, 32'd0);
    // set on an entry already in the list
    send_cmd(CMD_SET, 6'd1, 32'd5);
    // the sentinel cannot be set or freed
    send_cmd(CMD_SET, 6'd0, 32'd5);
    send_cmd(CMD_FREE, 6'd0, 32'd0);
    // free entry, same deadline as entry 1, goes in front
    send_cmd(CMD_SET, 6'd2, 32'd0);
    // deadline wraps to zero
    send_cmd(CMD_SET, 6'd63, DL_ALL_ONES);
    // deadline equal to the sentinel's
    send_cmd(CMD_SET, 6'd5, 32'hffff_fffe);
    send_cmd(CMD_SET, 6'd3, 32'd100);
  endtask

  // count reset with wrapping deadlines
  task automatic test_count_reset();
    send_cmd(CMD_TICK, '0, '0);
    send_cmd(CMD_TICK, '0, '0);
    send_cmd(CMD_RESET, '0, '0);
  endtask

  // free from the middle, the head, the tail and of non-listed entries
  task automatic test_free_paths();
    send_cmd(CMD_FREE, 6'd3, 32'd0);
    send_cmd(CMD_FREE, 6'd63, 32'd0);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_FREE, 6'd3, 32'd0);
    send_cmd(CMD_FREE, 6'd3, 32'd0);
    send_cmd(CMD_FREE, 6'd5, 32'd0);
    send_cmd(CMD_SET, 6'd4, 32'h8000_0000);
    send_cmd(CMD_RESET, '0, '0);
  endtask

  // run the pool dry, then free every entry but the sentinel
  task automatic test_pool_exhaustion();
    int spare;
    spare = 0;
    for (int i = 0; i < TIMER_COUNT; i++)
      if (pool_status[i] == STAT_FREE) spare++;
    repeat (spare + 1) send_cmd(CMD_ALLOC, IDX_W'($urandom), $urandom);
    for (int i = 1; i < TIMER_COUNT; i++) send_cmd(CMD_FREE, IDX_W'(i), $urandom);
  endtask

  // mostly alloc/set/free lifecycles over random deadlines
  task automatic test_random_traffic();
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [DL_W-1:0]  tmo;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 300 && k < 450);
      if (k == 100 || k == 500 || $urandom_range(199) == 0) drain_pause();
      r   = $urandom_range(99);
      idx = IDX_W'($urandom);
      tmo = $urandom;
      if (r < 20) begin
        cmd = CMD_ALLOC;
      end else if (r < 50) begin
        cmd = CMD_SET;
        tmo = pick_timeout();
        r = $urandom_range(99);
        if (r < 70) idx = pick_entry(STAT_ALLOC);
        else if (r < 85) idx = pick_entry(STAT_FREE);
        else if (r < 95) idx = pick_entry(STAT_INUSE);
      end else if (r < 68) begin
        cmd = CMD_FREE;
        r = $urandom_range(99);
        if (r < 60) idx = pick_entry(STAT_INUSE);
        else if (r < 80) idx = pick_entry(STAT_ALLOC);
      end else if (r < 88) begin
        cmd = CMD_TICK;
      end else if (r < 94) begin
        cmd = CMD_RESET;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      end
      send_cmd(cmd, idx, tmo);
    end
    calm = 1'b0;
  endtask

  initial begin
    pool_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_alloc_and_set();
    test_count_reset();
    test_free_paths();
    test_pool_exhaustion();
    test_random_traffic();
    // let the last replies drain
    in_valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
